// ===== hw/rtl/hcbd_pkg.sv =====
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam int PHASE_BITS = 3;

  localparam logic [PHASE_BITS-1:0] PH_SIZE   = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_EXT    = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_BAD    = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_DATA   = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_DROP_A = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_DROP_B = 3'd5;
  localparam logic [PHASE_BITS-1:0] PH_LAST   = 3'd6;
  localparam logic [PHASE_BITS-1:0] PH_HALT   = 3'd7;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/http_chunked_body_decoder_top.sv =====
// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | in_byte[7:0], restart
// output  | out_valid / out_stall| out_byte[7:0], kind[1:0]
//
// One byte per cycle unless the input stalls: the state update and the result
// are one level of logic between the decoder state and the output register.
// A transaction yields at most one result, shown in the cycle after acceptance.
// Input stalls only while the output register holds a result that is stalled.
// Synchronous active-high reset returns to the start of a size line.
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind
);

  logic [PHASE_BITS-1:0] phase, phase_next, ph;
  logic [SIZE_BITS-1:0]  size_accum, size_accum_next, acc;
  logic [SIZE_BITS-1:0]  bytes_left, bytes_left_next, left, left_dec;
  logic                  digit_seen, digit_seen_next, seen;
  logic                  digits_closed, digits_closed_next, closed;
  logic                  cr_pending, cr_pending_next, crp;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic [1:0]            emit_kind;
  logic                  line_end, is_space, accept;
  hex_t                  hx;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ph     = restart ? PH_SIZE : phase;
    acc    = restart ? '0 : size_accum;
    left   = restart ? '0 : bytes_left;
    seen   = restart ? 1'b0 : digit_seen;
    closed = restart ? 1'b0 : digits_closed;
    crp    = restart ? 1'b0 : cr_pending;

    phase_next         = ph;
    size_accum_next    = acc;
    bytes_left_next    = left;
    digit_seen_next    = seen;
    digits_closed_next = closed;
    cr_pending_next    = crp;
    emit               = 1'b0;
    emit_byte          = 8'd0;
    emit_kind          = KIND_DATA;

    line_end = crp && (in_byte == CH_LF);
    is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR);
    hx       = hex_digit(in_byte);
    left_dec = left - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    case (ph)
      PH_SIZE, PH_EXT: begin
        if (line_end) begin
          cr_pending_next = 1'b0;
          if (!seen) begin
            phase_next = PH_HALT;
            emit       = 1'b1;
            emit_kind  = KIND_ERR;
          end else if (acc == '0) begin
            phase_next = PH_LAST;
          end else begin
            bytes_left_next = acc;
            phase_next      = PH_DATA;
          end
        end else begin
          cr_pending_next = (in_byte == CH_CR);
          if (ph == PH_SIZE) begin
            if (is_space) begin
              if (seen) digits_closed_next = 1'b1;
            end else if (in_byte == CH_SEMI) begin
              phase_next = PH_EXT;
            end else if (!hx.ok || closed || (acc[SIZE_BITS-1 -: 4] != 4'd0)) begin
              phase_next = PH_BAD;
            end else begin
              size_accum_next = {acc[SIZE_BITS-5:0], hx.value};
              digit_seen_next = 1'b1;
            end
          end
        end
      end
      PH_BAD: begin
        if (line_end) begin
          cr_pending_next = 1'b0;
          phase_next      = PH_HALT;
          emit            = 1'b1;
          emit_kind       = KIND_ERR;
        end else begin
          cr_pending_next = (in_byte == CH_CR);
        end
      end
      PH_DATA: begin
        bytes_left_next = left_dec;
        if (left_dec == '0) phase_next = PH_DROP_A;
        emit      = 1'b1;
        emit_byte = in_byte;
        emit_kind = KIND_DATA;
      end
      PH_DROP_A: begin
        phase_next = PH_DROP_B;
      end
      PH_DROP_B: begin
        phase_next         = PH_SIZE;
        size_accum_next    = '0;
        digit_seen_next    = 1'b0;
        digits_closed_next = 1'b0;
        cr_pending_next    = 1'b0;
      end
      PH_LAST: begin
        if (line_end) begin
          cr_pending_next = 1'b0;
          phase_next      = PH_HALT;
          emit            = 1'b1;
          emit_kind       = KIND_DONE;
        end else begin
          cr_pending_next = (in_byte == CH_CR);
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      size_accum    <= '0;
      bytes_left    <= '0;
      digit_seen    <= 1'b0;
      digits_closed <= 1'b0;
      cr_pending    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      digit_seen    <= digit_seen_next;
      digits_closed <= digits_closed_next;
      cr_pending    <= cr_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte <= emit_byte;
      kind     <= emit_kind;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DATA) |-> (out_byte == 8'd0))
    else $error("status result carries a nonzero byte");

  a_halt_after_status: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && emit_kind != KIND_DATA) |=> (phase == PH_HALT))
    else $error("decoder not halted after completion or error");

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("payload phase with zero bytes left");
`endif

endmodule
